@@ rtl/tea_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types and constants for the TEA block cipher pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned KEY_WORDS = 4;
	localparam int unsigned APB_AW    = 4;

	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef logic [WORD_W-1:0] word_t;

	typedef word_t [KEY_WORDS-1:0] key_t;

	typedef struct packed {
		op_t   op;
		word_t z;
		word_t y;
	} blk_t;

endpackage

@@ rtl/tea_apb_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_apb_regs
// APB register file holding the four 32-bit key words.
// ----------------------------------------------------------------------------
module tea_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tea_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output tea_pkg::key_t              key
);
	import tea_pkg::*;

	key_t       key_q;
	logic [1:0] widx;
	logic       wr_en;

	assign widx   = paddr[APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = key_q[widx];
	assign key    = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			key_q[widx] <= pwdata;
		end
	end

endmodule

@@ rtl/tea_half_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_half_round
// One registered half round: updates one half of the block from the other.
// ----------------------------------------------------------------------------
module tea_half_round #(
	parameter int unsigned ROUNDS = 32,
	parameter int unsigned STAGE  = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  tea_pkg::key_t key,
	input  logic          vld_in,
	input  tea_pkg::blk_t blk_in,
	output logic          vld_out,
	output tea_pkg::blk_t blk_out
);
	import tea_pkg::*;

	localparam bit    IS_ODD  = (STAGE % 2) == 1;
	localparam word_t SUM_ENC = TEA_DELTA * 32'(STAGE / 2 + 1);
	localparam word_t SUM_DEC = TEA_DELTA * 32'(ROUNDS - STAGE / 2);

	function automatic word_t mix(word_t x, word_t sum, word_t ka, word_t kb);
		return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
	endfunction

	logic  enc;
	logic  upd_y;
	word_t a;
	word_t b;
	word_t ka;
	word_t kb;
	word_t sum;
	word_t m;
	word_t res;
	blk_t  nxt;
	logic  vld_s1;
	blk_t  blk_s1;

	always_comb begin
		enc   = (blk_in.op == OP_ENCRYPT);
		upd_y = enc ^ IS_ODD;
		a     = upd_y ? blk_in.y : blk_in.z;
		b     = upd_y ? blk_in.z : blk_in.y;
		ka    = upd_y ? key[0] : key[2];
		kb    = upd_y ? key[1] : key[3];
		sum   = enc ? SUM_ENC : SUM_DEC;
		m     = mix(b, sum, ka, kb);
		res   = enc ? (a + m) : (a - m);
		nxt   = blk_in;
		if (upd_y) begin
			nxt.y = res;
		end else begin
			nxt.z = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_s1 <= nxt;
		end
	end

	assign vld_out = vld_s1;
	assign blk_out = blk_s1;

endmodule

@@ rtl/tea_obuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_obuf
// Output register with a skid entry; stalls the pipeline only once full.
// ----------------------------------------------------------------------------
module tea_obuf (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] in_data,
	output logic        ready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata
);
	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic        skid_valid_q;
	logic [63:0] skid_data_q;
	logic        incoming;
	logic        taken;

	assign ready    = !skid_valid_q;
	assign incoming = in_valid && ready;
	assign taken    = out_valid_q && m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (taken) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= incoming;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= incoming;
		end else if (incoming) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (taken && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end else if (taken || !out_valid_q) begin
			out_data_q <= in_data;
		end else if (incoming) begin
			skid_data_q <= in_data;
		end
	end

	a_skid_implies_out : assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_skid_fill_on_stall : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready && in_valid))
		else $error("skid entry filled without a stalled output");

	a_skid_drains_first : assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && m_tready) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry not moved to output register");

endmodule

@@ rtl/tea_block_cipher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_top
// TEA block cipher, 64-bit block, 128-bit key, fully pipelined by half round.
//
// Channel   Dir  Signals                                Content
// s_*       in   s_tvalid s_tready s_tdata s_tuser      block in, opcode
// m_*       out  m_tvalid m_tready m_tdata              block out
// apb       in   psel penable pwrite paddr pwdata ...   key words 0..3
//
// One block is taken every cycle while s_tready is high; each block passes
// through 2*ROUNDS half-round stages and then the output register.
// Throughput is set by one half round (four 32-bit adds or subtracts and two XORs) per stage.
// Reset clears all valid bits and the key words.
// A stall on m_tready first fills the skid entry; only then is s_tready
// dropped and the whole pipeline held.
// ----------------------------------------------------------------------------
module tea_block_cipher_top #(
	parameter int unsigned ROUNDS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [63:0]                s_tdata,   // half_y [31:0], half_z [63:32]
	input  logic                       s_tuser,   // opcode [0]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [63:0]                m_tdata,   // out_y [31:0], out_z [63:32]
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tea_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import tea_pkg::*;

	localparam int unsigned NSTAGES = 2 * ROUNDS;

	key_t key;
	logic pipe_en;
	logic vld [0:NSTAGES];
	blk_t blk [0:NSTAGES];

	tea_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key     (key)
	);

	assign s_tready = pipe_en;
	assign vld[0]   = s_tvalid;
	assign blk[0]   = '{op: op_t'(s_tuser), z: s_tdata[63:32], y: s_tdata[31:0]};

	for (genvar i = 0; i < NSTAGES; i++) begin : g_stage
		tea_half_round #(
			.ROUNDS (ROUNDS),
			.STAGE  (i)
		) u_hr (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (pipe_en),
			.key     (key),
			.vld_in  (vld[i]),
			.blk_in  (blk[i]),
			.vld_out (vld[i+1]),
			.blk_out (blk[i+1])
		);
	end

	tea_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld[NSTAGES]),
		.in_data  ({blk[NSTAGES].z, blk[NSTAGES].y}),
		.ready    (pipe_en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_hold_on_stall : assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(vld[NSTAGES]))
		else $error("last pipeline stage changed while held");

	a_stall_needs_output : assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |-> m_tvalid)
		else $error("pipeline held with no result pending");

	a_stall_after_block : assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pipe_en) |-> $past(m_tvalid && !m_tready))
		else $error("pipeline held without a blocked output");

endmodule
